[design/fwc_pkg.sv]
// Shared types, constants and codes of the flash write-combining chunker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package fwc_pkg;

    // Buffer geometry.
    localparam int BUFFER_BYTES = 32;
    localparam int BUF_AW       = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);

    // Field widths.
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 13;
    localparam int BIDX_W = 12;
    localparam int LEN_W  = 17;
    localparam int CMAX_W = 6;
    localparam int EA_W   = 17;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_MAX   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_ALIGN = 1'b1;

    // Reset values of the configuration registers.
    localparam int CMAX_RESET = (BUFFER_BYTES < 32) ? BUFFER_BYTES : 32;
    localparam logic [EA_W-1:0] EA_RESET = 17'd4096;

    // Packets end at the latest after 4096 bytes, when the byte index reaches this value.
    localparam logic [BIDX_W-1:0] BIDX_MAX = 12'd4095;

    // Command codes of an input word.
    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Width of the serial remainder unit step counter.
    localparam int DIV_CNT_W = $clog2(ADDR_W + 1);

    // Work queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_ERASE  = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    // One unit of work handed from the front to the back, in this order:
    // an optional flush, an optional buffer store, an optional flush of a
    // full buffer, and an optional status word.
    typedef struct packed {
        logic              fa_en;
        logic [ADDR_W-1:0] fa_base;
        logic [CNT_W-1:0]  fa_cnt;
        logic              st_en;
        logic [BUF_AW-1:0] st_idx;
        logic [BYTE_W-1:0] st_byte;
        logic              fb_en;
        logic [ADDR_W-1:0] fb_base;
        logic              stat_en;
        logic              stat_ok;
    } fwc_entry_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MOD,
        BK_CHUNK,
        BK_ERASE,
        BK_WRITE,
        BK_STORE,
        BK_STATUS
    } back_state_t;

endpackage

`default_nettype wire

[design/fwc_front.sv]
// Front end: accepts input words, tracks the buffered address run and the
// packet position, and turns each word into one work entry. Uses fwc_pkg.
`default_nettype none

module fwc_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       cmd,
    input  wire logic [fwc_pkg::ADDR_W-1:0] packet_addr,
    input  wire logic [fwc_pkg::SIZE_W-1:0] packet_size,
    input  wire logic [fwc_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       clear,
    input  wire logic                       q_full,
    output logic                            push,
    output fwc_pkg::fwc_entry_t             entry
);
    import fwc_pkg::*;

    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [BIDX_W-1:0] bidx_reg, bidx_next;
    logic              rej_reg, rej_next;

    logic [SIZE_W-1:0] psize_eff;
    logic [ADDR_W-1:0] run_end;
    logic [CNT_W-1:0]  free_bytes;
    logic              first_byte;
    logic              flush_a;
    logic              rej;
    logic [CNT_W-1:0]  fill_a;
    logic [CNT_W-1:0]  fill_s;
    logic [ADDR_W-1:0] base_a;
    logic [ADDR_W-1:0] base_s;
    logic              full;
    logic              pkt_end;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Classify the word and work out the new bookkeeping state.
    always_comb
    begin
        psize_eff  = (packet_size == '0) ? SIZE_W'(1) : packet_size;
        run_end    = base_reg + ADDR_W'(fill_reg);
        free_bytes = CNT_W'(BUFFER_BYTES) - fill_reg;
        first_byte = (bidx_reg == '0);

        flush_a = first_byte &&
                  ((psize_eff > SIZE_W'(free_bytes)) || (packet_addr != run_end));
        rej     = first_byte ? (psize_eff > SIZE_W'(BUFFER_BYTES)) : rej_reg;
        fill_a  = flush_a ? '0 : fill_reg;
        base_a  = flush_a ? run_end : base_reg;
        base_s  = (fill_a == '0) ? (packet_addr + ADDR_W'(bidx_reg)) : base_a;
        fill_s  = fill_a + CNT_W'(1);
        full    = !rej && (fill_s == CNT_W'(BUFFER_BYTES));
        pkt_end = (({1'b0, bidx_reg} + SIZE_W'(1)) >= psize_eff) || (bidx_reg == BIDX_MAX);

        entry.st_byte = data_byte;
        entry.st_idx  = fill_a[BUF_AW-1:0];
        entry.fa_base = base_reg;
        entry.fa_cnt  = fill_reg;
        entry.fb_base = base_reg;

        if (cmd == CMD_FINISH)
        begin
            entry.fa_en   = (fill_reg != '0);
            entry.st_en   = 1'b0;
            entry.fb_en   = 1'b0;
            entry.stat_en = 1'b1;
            entry.stat_ok = 1'b1;
            base_next     = run_end;
            fill_next     = '0;
            bidx_next     = '0;
            rej_next      = 1'b0;
        end
        else
        begin
            entry.fa_en   = flush_a && (fill_reg != '0);
            entry.st_en   = !rej;
            // A full buffer can only follow a store into a non-empty run,
            // so the run base is still the registered one.
            entry.fb_en   = full;
            entry.stat_en = pkt_end;
            entry.stat_ok = !rej;
            if (rej)
            begin
                base_next = base_a;
                fill_next = fill_a;
            end
            else if (full)
            begin
                base_next = base_reg + ADDR_W'(BUFFER_BYTES);
                fill_next = '0;
            end
            else
            begin
                base_next = base_s;
                fill_next = fill_s;
            end
            bidx_next = pkt_end ? '0 : (bidx_reg + BIDX_W'(1));
            rej_next  = pkt_end ? 1'b0 : rej;
        end
    end

    // Bookkeeping registers; a chunk size write empties the buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            base_reg <= '0;
            bidx_reg <= '0;
            rej_reg  <= 1'b0;
        end
        else if (clear)
        begin
            fill_reg <= '0;
            base_reg <= '0;
        end
        else if (push)
        begin
            fill_reg <= fill_next;
            base_reg <= base_next;
            bidx_reg <= bidx_next;
            rej_reg  <= rej_next;
        end
    end

endmodule

`default_nettype wire

[design/fwc_queue.sv]
// Short work queue between the front end and the back end.
// Holds fwc_pkg::fwc_entry_t words; uses fwc_pkg.
`default_nettype none

module fwc_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire fwc_pkg::fwc_entry_t push_data,
    input  wire logic                pop,
    output fwc_pkg::fwc_entry_t      pop_data,
    output logic                     full,
    output logic                     empty
);
    import fwc_pkg::*;

    fwc_entry_t        slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : (wr_ptr_reg + QPTR_W'(1));
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : (rd_ptr_reg + QPTR_W'(1));
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[design/fwc_mod.sv]
// Serial remainder unit: address modulo erase block size, one dividend
// bit per cycle. Uses fwc_pkg.
`default_nettype none

module fwc_mod (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [fwc_pkg::ADDR_W-1:0] dividend,
    input  wire logic [fwc_pkg::EA_W-1:0]   divisor,
    output logic                            done,
    output logic [fwc_pkg::EA_W-1:0]        remainder
);
    import fwc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ADDR_W-1:0]    dvd_reg;
    logic [EA_W-1:0]      rem_reg, rem_next;
    logic [EA_W:0]        trial;

    assign done      = done_reg;
    assign remainder = rem_reg;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[ADDR_W-1]};
        rem_next = (trial >= {1'b0, divisor}) ? EA_W'(trial - {1'b0, divisor})
                                              : trial[EA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(ADDR_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath of the division.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ADDR_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

[design/fwc_back.sv]
// Back end: owns the byte buffer, carries out work entries (flushes cut
// into chunks with erase words, stores, status) and drives the output
// register. Uses fwc_pkg and fwc_mod.
`default_nettype none

module fwc_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_empty,
    input  wire fwc_pkg::fwc_entry_t        q_data,
    output logic                            q_pop,
    input  wire logic [fwc_pkg::CNT_W-1:0]  cmax,
    input  wire logic [fwc_pkg::EA_W-1:0]   ea,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [fwc_pkg::KIND_W-1:0]      kind,
    output logic [fwc_pkg::ADDR_W-1:0]      target_addr,
    output logic [fwc_pkg::LEN_W-1:0]       length,
    output logic [fwc_pkg::BYTE_W-1:0]      out_byte,
    output logic                            chunk_first,
    output logic                            chunk_last,
    output logic                            ok,
    output logic                            last
);
    import fwc_pkg::*;

    back_state_t       state_reg, state_next;
    fwc_entry_t        ent_reg, ent_next;
    logic              phase_b_reg, phase_b_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  size_reg, size_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [EA_W-1:0]   mod_reg, mod_next;

    logic [BYTE_W-1:0] buf_mem [BUFFER_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_we;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [ADDR_W-1:0] target_addr_reg, target_addr_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              chunk_first_reg, chunk_first_next;
    logic              chunk_last_reg, chunk_last_next;
    logic              ok_reg, ok_next;
    logic              last_reg, last_next;
    logic              out_load;

    logic              slot_free;
    logic [CNT_W-1:0]  chunk_size;
    logic              erase_hit;
    logic              k_last;
    logic [CNT_W-1:0]  rem_after;
    logic              flush_done;
    logic              final_flush;
    logic [EA_W:0]     mod_inc;
    logic              mod_start;
    logic [ADDR_W-1:0] mod_dividend;
    logic              mod_done;
    logic [EA_W-1:0]   mod_rem;
    back_state_t       flush_entry_state;
    back_state_t       after_flush_state;

    fwc_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (ea),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign target_addr = target_addr_reg;
    assign length      = length_reg;
    assign out_byte    = out_byte_reg;
    assign chunk_first = chunk_first_reg;
    assign chunk_last  = chunk_last_reg;
    assign ok          = ok_reg;
    assign last        = last_reg;

    // Shared conditions of the flush walk.
    always_comb
    begin
        slot_free   = !out_valid_reg || out_ready;
        chunk_size  = (cmax < rem_reg) ? cmax : rem_reg;
        erase_hit   = (ea != '0) && (mod_reg == '0);
        k_last      = ((k_reg + CNT_W'(1)) == size_reg);
        rem_after   = rem_reg - size_reg;
        flush_done  = k_last && (rem_after == '0);
        final_flush = phase_b_reg ? !ent_reg.stat_en : (!ent_reg.fb_en && !ent_reg.stat_en);
        mod_inc     = {1'b0, mod_reg} + (EA_W + 1)'(1);
        flush_entry_state = (ea != '0) ? BK_MOD : BK_CHUNK;
        if (phase_b_reg)
        begin
            after_flush_state = ent_reg.stat_en ? BK_STATUS : BK_IDLE;
        end
        else if (ent_reg.st_en)
        begin
            after_flush_state = BK_STORE;
        end
        else
        begin
            after_flush_state = ent_reg.stat_en ? BK_STATUS : BK_IDLE;
        end
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_data.fa_en)
                    begin
                        state_next = flush_entry_state;
                    end
                    else if (q_data.st_en)
                    begin
                        state_next = BK_STORE;
                    end
                    else if (q_data.stat_en)
                    begin
                        state_next = BK_STATUS;
                    end
                end
            end
            BK_MOD:
            begin
                if (mod_done)
                begin
                    state_next = BK_CHUNK;
                end
            end
            BK_CHUNK:
            begin
                state_next = erase_hit ? BK_ERASE : BK_WRITE;
            end
            BK_ERASE:
            begin
                if (slot_free)
                begin
                    state_next = BK_WRITE;
                end
            end
            BK_WRITE:
            begin
                if (slot_free && k_last)
                begin
                    state_next = flush_done ? after_flush_state : BK_CHUNK;
                end
            end
            BK_STORE:
            begin
                if (ent_reg.fb_en)
                begin
                    state_next = flush_entry_state;
                end
                else
                begin
                    state_next = ent_reg.stat_en ? BK_STATUS : BK_IDLE;
                end
            end
            BK_STATUS:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath, buffer and output word for each state.
    always_comb
    begin
        ent_next         = ent_reg;
        phase_b_next     = phase_b_reg;
        addr_next        = addr_reg;
        pos_next         = pos_reg;
        rem_next         = rem_reg;
        size_next        = size_reg;
        k_next           = k_reg;
        mod_next         = mod_reg;
        q_pop            = 1'b0;
        mem_we           = 1'b0;
        mod_start        = 1'b0;
        mod_dividend     = q_data.fa_base;
        out_load         = 1'b0;
        kind_next        = KIND_STATUS;
        target_addr_next = '0;
        length_next      = '0;
        out_byte_next    = '0;
        chunk_first_next = 1'b0;
        chunk_last_next  = 1'b0;
        ok_next          = 1'b0;
        last_next        = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    ent_next     = q_data;
                    phase_b_next = 1'b0;
                    addr_next    = q_data.fa_base;
                    rem_next     = q_data.fa_cnt;
                    pos_next     = '0;
                    mod_start    = q_data.fa_en && (ea != '0);
                end
            end
            BK_MOD:
            begin
                if (mod_done)
                begin
                    mod_next = mod_rem;
                end
            end
            BK_CHUNK:
            begin
                size_next = chunk_size;
                k_next    = '0;
            end
            BK_ERASE:
            begin
                if (slot_free)
                begin
                    out_load         = 1'b1;
                    kind_next        = KIND_ERASE;
                    target_addr_next = addr_reg;
                    length_next      = LEN_W'(ea);
                end
            end
            BK_WRITE:
            begin
                if (slot_free)
                begin
                    out_load         = 1'b1;
                    kind_next        = KIND_WRITE;
                    target_addr_next = addr_reg;
                    length_next      = LEN_W'(size_reg);
                    out_byte_next    = rd_data_reg;
                    chunk_first_next = (k_reg == '0);
                    chunk_last_next  = k_last;
                    last_next        = flush_done && final_flush;
                    addr_next        = addr_reg + ADDR_W'(1);
                    pos_next         = pos_reg + CNT_W'(1);
                    k_next           = k_reg + CNT_W'(1);
                    // Address zero after the wrap is always aligned.
                    if (addr_reg == '1)
                    begin
                        mod_next = '0;
                    end
                    else
                    begin
                        mod_next = (mod_inc == {1'b0, ea}) ? '0 : mod_inc[EA_W-1:0];
                    end
                    if (k_last)
                    begin
                        rem_next = rem_after;
                    end
                end
            end
            BK_STORE:
            begin
                mem_we = 1'b1;
                if (ent_reg.fb_en)
                begin
                    phase_b_next = 1'b1;
                    addr_next    = ent_reg.fb_base;
                    rem_next     = CNT_W'(BUFFER_BYTES);
                    pos_next     = '0;
                    mod_start    = (ea != '0);
                    mod_dividend = ent_reg.fb_base;
                end
            end
            BK_STATUS:
            begin
                if (slot_free)
                begin
                    out_load  = 1'b1;
                    kind_next = KIND_STATUS;
                    ok_next   = ent_reg.stat_ok;
                    last_next = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        ent_reg     <= ent_next;
        phase_b_reg <= phase_b_next;
        addr_reg    <= addr_next;
        pos_reg     <= pos_next;
        rem_reg     <= rem_next;
        size_reg    <= size_next;
        k_reg       <= k_next;
        mod_reg     <= mod_next;
        if (out_load)
        begin
            kind_reg        <= kind_next;
            target_addr_reg <= target_addr_next;
            length_reg      <= length_next;
            out_byte_reg    <= out_byte_next;
            chunk_first_reg <= chunk_first_next;
            chunk_last_reg  <= chunk_last_next;
            ok_reg          <= ok_next;
            last_reg        <= last_next;
        end
    end

    // Byte buffer: one write port, one registered read that follows the
    // walk position so the byte is ready when its word is emitted.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            buf_mem[ent_reg.st_idx] <= ent_reg.st_byte;
        end
        rd_data_reg <= buf_mem[pos_next[BUF_AW-1:0]];
    end

endmodule

`default_nettype wire

[design/flash_write_combine_chunker_core.sv]
// Flash write-combining chunker. A word enters the work queue at its accepting edge and
// the back end pops it when idle; it then stores a byte in BK_STORE and presents a status
// word from BK_STATUS after its other steps. The queue lets the front end accept words while
// the back end is busy. A flush runs the serial address-modulo unit (skipped when the erase
// size is zero), then per chunk a chunk step, an optional erase word and one write word per
// data byte, with output stalls, all in the back end.
`default_nettype none

module flash_write_combine_chunker_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [fwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fwc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           cmd,
    input  wire logic [fwc_pkg::ADDR_W-1:0]     packet_addr,
    input  wire logic [fwc_pkg::SIZE_W-1:0]     packet_size,
    input  wire logic [fwc_pkg::BYTE_W-1:0]     data_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [fwc_pkg::KIND_W-1:0]          kind,
    output logic [fwc_pkg::ADDR_W-1:0]          target_addr,
    output logic [fwc_pkg::LEN_W-1:0]           length,
    output logic [fwc_pkg::BYTE_W-1:0]          out_byte,
    output logic                                chunk_first,
    output logic                                chunk_last,
    output logic                                ok,
    output logic                                last
);
    import fwc_pkg::*;

    // Reset empties the buffer, clears the run base and packet position, and sets
    // the chunk size to 32 and the erase size to 4096.

    logic [CNT_W-1:0]  chunk_max_reg;
    logic [EA_W-1:0]   erase_align_reg;
    logic [CMAX_W-1:0] cmax_wr;
    logic [CNT_W-1:0]  cmax_eff;
    logic              clear;

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    fwc_entry_t        push_entry;
    fwc_entry_t        pop_entry;

    // Configuration registers; the chunk size is clamped to the buffer.
    always_comb
    begin
        cmax_wr  = cfg_data[CMAX_W-1:0];
        if (cmax_wr > CMAX_W'(BUFFER_BYTES))
        begin
            cmax_wr = CMAX_W'(BUFFER_BYTES);
        end
        cmax_eff = (chunk_max_reg == '0) ? CNT_W'(1) : chunk_max_reg;
        clear    = cfg_we && (cfg_index == CFG_CHUNK_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_max_reg   <= CNT_W'(CMAX_RESET);
            erase_align_reg <= EA_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_CHUNK_MAX)
            begin
                chunk_max_reg <= CNT_W'(cmax_wr);
            end
            else
            begin
                erase_align_reg <= cfg_data[EA_W-1:0];
            end
        end
    end

    fwc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .packet_addr (packet_addr),
        .packet_size (packet_size),
        .data_byte   (data_byte),
        .clear       (clear),
        .q_full      (q_full),
        .push        (push),
        .entry       (push_entry)
    );

    fwc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (pop_entry),
        .full      (q_full),
        .empty     (q_empty)
    );

    fwc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (pop_entry),
        .q_pop       (pop),
        .cmax        (cmax_eff),
        .ea          (erase_align_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .target_addr (target_addr),
        .length      (length),
        .out_byte    (out_byte),
        .chunk_first (chunk_first),
        .chunk_last  (chunk_last),
        .ok          (ok),
        .last        (last)
    );

endmodule

`default_nettype wire

[test/flash_write_combine_chunker_core_test.sv]
// Testbench for the flash write-combining chunker core: a directed table, then random packets.
// Each output word is checked against an in-file predictor of the buffer and its flushes,
// or a directed row's expectation. Depends on fwc_pkg and flash_write_combine_chunker_core.
`timescale 1ns / 100ps

module flash_write_combine_chunker_core_test;

    import fwc_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned N_PHASES      = 8;
    localparam int unsigned PHASE_WORDS   = 46;
    localparam int unsigned RAND_EA_PHASE = 6;

    // Register settings of the random phases, extremes included.
    localparam logic [CMAX_W-1:0] PH_CMAX [N_PHASES] = '{2, 32, 5, 0, 7, 63, 1, 32};
    localparam logic [EA_W-1:0]   PH_EA   [N_PHASES] = '{1, 65536, 8, 0, 3, 16, 1, 4096};

    // One input word as the sender drives it.
    typedef struct packed {
        logic              cmd_v;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [BYTE_W-1:0] data;
    } in_word_t;

    // One output word of the block.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
        logic              ch_first;
        logic              ch_last;
        logic              ok_b;
        logic              last_b;
    } flash_op_t;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    // How a directed row is checked: by the predictor, no output, or one status word.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_STATUS
    } row_check_t;

    typedef struct packed {
        row_kind_t             rk;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  cmd_v;
        logic [ADDR_W-1:0]     addr;
        logic [SIZE_W-1:0]     size;
        logic [BYTE_W-1:0]     data;
        row_check_t            chk;
        logic                  ok_v;
    } dir_row_t;

    localparam int unsigned N_DIRECTED = 22;

    // Directed stimulus, starting from the reset settings (chunk 32, erase 4096).
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // Finish on an empty buffer gives only a status word.
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_FINISH, 32'h0000_0000, 13'd0, 8'h00, CHK_STATUS, 1'b1},
        // A three-byte packet on an erase boundary, then finish.
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'h0000_1000, 13'd3, 8'h00, CHK_NONE, 1'b0},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'h0000_1000, 13'd3, 8'hFF, CHK_NONE, 1'b0},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'h0000_1000, 13'd3, 8'h5A, CHK_STATUS, 1'b1},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_FINISH, 32'h0000_0000, 13'd0, 8'h00, CHK_MODEL, 1'b0},
        // Oversized packet whose size drops to one on its second byte: rejected.
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'hFFFF_FFFF, 13'h1FFF, 8'hA5, CHK_NONE, 1'b0},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'hFFFF_FFFF, 13'd1, 8'hA5, CHK_STATUS, 1'b0},
        // Zero size acts as one byte; the run then continues across the address wrap.
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'hFFFF_FFFE, 13'd0, 8'h11, CHK_STATUS, 1'b1},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'hFFFF_FFFF, 13'd2, 8'h22, CHK_NONE, 1'b0},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'hFFFF_FFFF, 13'd2, 8'h33, CHK_STATUS, 1'b1},
        // A packet that breaks the run flushes the wrapped chunk, then finish cuts it short.
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'h0000_0000, 13'd20, 8'h44, CHK_MODEL, 1'b0},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'h0000_0000, 13'd20, 8'h55, CHK_NONE, 1'b0},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_FINISH, 32'h0000_0000, 13'd0, 8'h00, CHK_MODEL, 1'b0},
        // Chunk limit zero acts as one; erase size zero suppresses erases.
        '{ROW_REG, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'h0, 13'd0, 8'h00, CHK_MODEL, 1'b0},
        '{ROW_REG, CFG_ERASE_ALIGN, 17'h0, CMD_BYTE, 32'h0, 13'd0, 8'h00, CHK_MODEL, 1'b0},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'h0000_0010, 13'd2, 8'h66, CHK_NONE, 1'b0},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'h0000_0010, 13'd2, 8'h99, CHK_STATUS, 1'b1},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_FINISH, 32'h0000_0000, 13'd0, 8'h00, CHK_MODEL, 1'b0},
        // Chunk limit above the buffer size clamps; erase size 65536.
        '{ROW_REG, CFG_CHUNK_MAX, 17'h1FFFF, CMD_BYTE, 32'h0, 13'd0, 8'h00, CHK_MODEL, 1'b0},
        '{ROW_REG, CFG_ERASE_ALIGN, 17'h10000, CMD_BYTE, 32'h0, 13'd0, 8'h00, CHK_MODEL, 1'b0},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_BYTE, 32'h0001_0000, 13'd1, 8'hC3, CHK_STATUS, 1'b1},
        '{ROW_WORD, CFG_CHUNK_MAX, 17'h0, CMD_FINISH, 32'h0000_0000, 13'd0, 8'h00, CHK_MODEL, 1'b0}
    };

    // Block ports.
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic                  cmd         = CMD_BYTE;
    logic [ADDR_W-1:0]     packet_addr = '0;
    logic [SIZE_W-1:0]     packet_size = '0;
    logic [BYTE_W-1:0]     data_byte   = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [KIND_W-1:0]     kind;
    logic [ADDR_W-1:0]     target_addr;
    logic [LEN_W-1:0]      length;
    logic [BYTE_W-1:0]     out_byte;
    logic                  chunk_first;
    logic                  chunk_last;
    logic                  ok;
    logic                  last;

    // Predictor state: combine buffer, run and packet position, registers.
    logic [BYTE_W-1:0] comb_mem [BUFFER_BYTES];
    int unsigned       fill       = 0;
    logic [ADDR_W-1:0] run_base   = '0;
    int unsigned       pkt_pos    = 0;
    logic              pkt_drop   = 1'b0;
    int unsigned       chunk_lim  = CMAX_RESET;
    logic [EA_W-1:0]   erase_size = EA_RESET;

    // Output words still owed by the block, oldest first.
    flash_op_t due_ops [$];

    int unsigned errors          = 0;
    int unsigned words_sent      = 0;
    int unsigned words_checked   = 0;
    int unsigned erases_seen     = 0;
    int unsigned packets_dropped = 0;
    int unsigned reg_writes      = 0;
    int unsigned stall_left      = 0;
    bit          no_gaps         = 1'b0;

    flash_write_combine_chunker_core dut (.*);

    always #10 clk = ~clk;

    function automatic int unsigned draw_gap();
        if (no_gaps)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic in_word_t pack_word(logic c, logic [ADDR_W-1:0] a,
                                           logic [SIZE_W-1:0] s, logic [BYTE_W-1:0] d);
        in_word_t w;
        w.cmd_v = c;
        w.addr  = a;
        w.size  = s;
        w.data  = d;
        return w;
    endfunction

    function automatic flash_op_t make_op(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] a,
                                          logic [LEN_W-1:0] l, logic [BYTE_W-1:0] d,
                                          logic f, logic lc, logic o);
        flash_op_t op;
        op.kind     = k;
        op.addr     = a;
        op.len      = l;
        op.data     = d;
        op.ch_first = f;
        op.ch_last  = lc;
        op.ok_b     = o;
        op.last_b   = 1'b0;
        return op;
    endfunction

    function automatic flash_op_t status_op(logic o);
        return make_op(KIND_STATUS, '0, '0, '0, 1'b0, 1'b0, o);
    endfunction

    function automatic string op_text(flash_op_t op);
        return $sformatf("kind=%0d addr=%h len=%0d data=%h first=%b lastc=%b ok=%b last=%b",
                         op.kind, op.addr, op.len, op.data, op.ch_first, op.ch_last,
                         op.ok_b, op.last_b);
    endfunction

    task automatic log_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Flush: cut the buffered run into chunks, erase on aligned chunk starts.
    task automatic drain_buffer();
        logic [ADDR_W-1:0] a;
        int unsigned pos, rem, sz, cm;
        a   = run_base;
        pos = 0;
        rem = fill;
        cm  = (chunk_lim < 1) ? 1 : chunk_lim;
        while (rem != 0)
        begin
            sz = (cm < rem) ? cm : rem;
            if (erase_size != 0 && (a % ADDR_W'(erase_size)) == 0)
                due_ops.push_back(make_op(KIND_ERASE, a, erase_size, '0, 1'b0, 1'b0, 1'b0));
            for (int unsigned k = 0; k < sz; k++)
                due_ops.push_back(make_op(KIND_WRITE, a + ADDR_W'(k), LEN_W'(sz),
                                          comb_mem[(pos + k) % BUFFER_BYTES],
                                          k == 0, k + 1 == sz, 1'b0));
            a   = a + ADDR_W'(sz);
            pos = pos + sz;
            rem = rem - sz;
        end
        run_base = run_base + ADDR_W'(fill);
        fill     = 0;
    endtask

    // Work out the output words caused by one accepted input word.
    task automatic predict_ops(input in_word_t w, input row_check_t chk, input logic ok_v);
        int unsigned n0, sz;
        flash_op_t   tail;
        n0 = due_ops.size();
        if (w.cmd_v == CMD_FINISH)
        begin
            drain_buffer();
            due_ops.push_back(status_op(1'b1));
            pkt_pos  = 0;
            pkt_drop = 1'b0;
        end
        else
        begin
            sz = (w.size == 0) ? 1 : w.size;
            // The first byte of a packet decides on a flush and on rejection.
            if (pkt_pos == 0)
            begin
                if (sz > BUFFER_BYTES - fill || w.addr != run_base + ADDR_W'(fill))
                    drain_buffer();
                pkt_drop = (sz > BUFFER_BYTES);
            end
            if (!pkt_drop)
            begin
                if (fill == 0)
                    run_base = w.addr + ADDR_W'(pkt_pos);
                comb_mem[fill % BUFFER_BYTES] = w.data;
                fill++;
                if (fill >= BUFFER_BYTES)
                    drain_buffer();
            end
            if (pkt_pos + 1 >= sz || pkt_pos >= BIDX_MAX)
            begin
                if (pkt_drop)
                    packets_dropped++;
                due_ops.push_back(status_op(!pkt_drop));
                pkt_pos  = 0;
                pkt_drop = 1'b0;
            end
            else
            begin
                pkt_pos++;
            end
        end
        // Directed rows with a typed expectation replace the predicted words.
        if (chk != CHK_MODEL)
        begin
            while (due_ops.size() > n0)
                void'(due_ops.pop_back());
            if (chk == CHK_STATUS)
                due_ops.push_back(status_op(ok_v));
        end
        if (due_ops.size() > n0)
        begin
            tail        = due_ops.pop_back();
            tail.last_b = 1'b1;
            due_ops.push_back(tail);
        end
    endtask

    // Present one input word at a falling edge and hold it until accepted.
    task automatic send_word(input in_word_t w, input row_check_t chk, input logic ok_v);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        cmd         = w.cmd_v;
        packet_addr = w.addr;
        packet_size = w.size;
        data_byte   = w.data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_ops(w, chk, ok_v);
        words_sent++;
        @(negedge clk);
    endtask

    // Wait until every owed word has arrived and the block has gone quiet.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (due_ops.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write, only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_CHUNK_MAX)
        begin
            chunk_lim = (val[CMAX_W-1:0] > BUFFER_BYTES) ? BUFFER_BYTES : val[CMAX_W-1:0];
            fill      = 0;
            run_base  = '0;
        end
        else
        begin
            erase_size = val[EA_W-1:0];
        end
        reg_writes++;
    endtask

    // The bytes of one packet; a messy packet may be cut by a finish or change its size.
    task automatic send_packet(input logic [ADDR_W-1:0] a, input logic [SIZE_W-1:0] sz,
                               input int unsigned nb, input bit messy);
        for (int unsigned i = 0; i < nb; i++)
        begin
            if (messy && $urandom_range(0, 99) < 3)
            begin
                send_word(pack_word(CMD_FINISH, $urandom, SIZE_W'($urandom), BYTE_W'($urandom)),
                          CHK_MODEL, 1'b0);
                return;
            end
            if (messy && $urandom_range(0, 99) < 3)
                sz = SIZE_W'($urandom_range(1, 40));
            send_word(pack_word(CMD_BYTE, a, sz, BYTE_W'($urandom)), CHK_MODEL, 1'b0);
        end
    endtask

    // Mostly well-formed packets near the run, erase boundaries and the address wrap.
    task automatic random_phase(input int unsigned quota);
        int unsigned       start, pick, nb;
        logic [ADDR_W-1:0] a;
        logic [SIZE_W-1:0] sz;
        start = words_sent;
        while (words_sent - start < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_word(pack_word(CMD_FINISH, $urandom, SIZE_W'($urandom), BYTE_W'($urandom)),
                          CHK_MODEL, 1'b0);
            end
            else if (pick < 14)
            begin
                send_word(pack_word(CMD_BYTE, $urandom, SIZE_W'($urandom_range(0, 8191)),
                                    BYTE_W'($urandom)), CHK_MODEL, 1'b0);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    sz = SIZE_W'($urandom_range(1, 8));
                else if (pick < 85)
                    sz = SIZE_W'($urandom_range(9, BUFFER_BYTES));
                else if (pick < 94)
                    sz = SIZE_W'($urandom_range(BUFFER_BYTES + 1, 48));
                else
                    sz = '0;
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    a = run_base + ADDR_W'(fill);
                else if (pick < 72 && erase_size != 0)
                    a = ADDR_W'($urandom_range(0, 255)) * ADDR_W'(erase_size)
                        - ADDR_W'($urandom_range(0, 2));
                else if (pick < 82)
                    a = '1 - ADDR_W'($urandom_range(0, 40));
                else
                    a = $urandom;
                nb = (sz == 0) ? 1 : sz;
                send_packet(a, sz, nb, 1'b1);
            end
        end
    endtask

    // Output side: ready stays low while the wait drawn after the last word runs down.
    always @(negedge clk)
    begin
        out_ready = (stall_left == 0);
    end

    // Compare every accepted output word with the oldest owed one.
    always @(posedge clk)
    begin : check_out
        flash_op_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind     = kind;
            got.addr     = target_addr;
            got.len      = length;
            got.data     = out_byte;
            got.ch_first = chunk_first;
            got.ch_last  = chunk_last;
            got.ok_b     = ok;
            got.last_b   = last;
            if (due_ops.size() == 0)
            begin
                log_error($sformatf("tb: unexpected output word %s", op_text(got)));
            end
            else
            begin
                want = due_ops.pop_front();
                if (got !== want)
                    log_error($sformatf("tb: mismatch at output word %0d\n  expected %s\n  actual   %s",
                                        words_checked, op_text(want), op_text(got)));
            end
            if (got.kind == KIND_ERASE)
                erases_seen++;
            words_checked++;
            stall_left = draw_gap();
        end
        else if (stall_left != 0)
        begin
            stall_left--;
        end
    end

    initial
    begin : stimulus
        dir_row_t          row;
        logic [EA_W-1:0]   ea_v;
        logic [CFG_DATA_W-1:0] cm_v;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table.
        for (int unsigned r = 0; r < N_DIRECTED; r++)
        begin
            row = DIRECTED[r];
            if (row.rk == ROW_REG)
                write_reg(row.reg_idx, row.reg_val);
            else
                send_word(pack_word(row.cmd_v, row.addr, row.size, row.data), row.chk, row.ok_v);
        end

        // Random phases, each under its own register setting.
        for (int unsigned p = 0; p < N_PHASES; p++)
        begin
            cm_v = (CFG_DATA_W'($urandom_range(0, 2047)) << CMAX_W) | CFG_DATA_W'(PH_CMAX[p]);
            ea_v = (p == RAND_EA_PHASE) ? EA_W'($urandom_range(1, 65536)) : PH_EA[p];
            write_reg(CFG_CHUNK_MAX, cm_v);
            write_reg(CFG_ERASE_ALIGN, CFG_DATA_W'(ea_v));
            no_gaps = (p % 3 == 2);
            random_phase(PHASE_WORDS);
        end

        // Flush whatever the last phase left behind.
        send_word(pack_word(CMD_FINISH, '0, '0, '0), CHK_MODEL, 1'b0);

        wait_drained();
        $display("tb: %0d input words and %0d register writes driven, %0d output words checked",
                 words_sent, reg_writes, words_checked);
        $display("tb: %0d erase words seen, %0d packets rejected, %0d mismatches",
                 erases_seen, packets_dropped, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard limit on the run time.
    initial
    begin : watchdog
        #60_000_000;
        $display("tb: timeout with %0d output words still owed", due_ops.size());
        $display("tb: failure");
        $finish;
    end

endmodule
